// ----- sv/d2c_pkg.sv -----
`timescale 1ns / 1ps

package d2c_pkg;

    localparam int COORD_BITS = 12;

    localparam int RAW_W     = 16;
    localparam int SCALE_W   = 32;
    localparam int P_W       = RAW_W + SCALE_W;
    localparam int Q_FRAC    = 16;
    localparam int DQ_W      = P_W - Q_FRAC;
    localparam int FOC_W     = 16;
    localparam int INTR_FRAC = 4;
    localparam int PIX_W     = COORD_BITS + INTR_FRAC;
    localparam int DIFF_W    = ((PIX_W > FOC_W) ? PIX_W : FOC_W) + 1;

    localparam int NQ_W      = DIFF_W - 1 + Q_FRAC;
    localparam int ND_STEP   = 4;
    localparam int ND_STAGES = (NQ_W + ND_STEP - 1) / ND_STEP;
    localparam int NDV_W     = ND_STAGES * ND_STEP;
    localparam int NMAG_W    = 31;

    localparam int MX_W      = DQ_W + NMAG_W;
    localparam int LAT_W     = 40;
    localparam int ROT_W     = 20;
    localparam int ROT_FRAC  = 18;
    localparam int PROD_W    = ROT_W + LAT_W;
    localparam int ACC_W     = PROD_W + 1;
    localparam int PT_W      = 44;
    localparam int PRJ_W     = FOC_W + 1 + PT_W;
    localparam int SUM_W     = PRJ_W + 1;
    localparam int PNUM_W    = 64;
    localparam int PDEN_W    = 50;
    localparam int CMP_W     = PNUM_W + COORD_BITS;
    localparam int PRJ_STAGES = COORD_BITS + 1;

    localparam int PADDR_W   = 6;
    localparam int PDATA_W   = 64;
    localparam int ROW_W     = 60;
    localparam int FRAME_W   = 2 * COORD_BITS;

    typedef enum logic [2:0] {
        REG_DEPTH_SCALE = 3'd0,
        REG_DEPTH_INTR  = 3'd1,
        REG_COLOR_INTR  = 3'd2,
        REG_ROT_ROW0    = 3'd3,
        REG_ROT_ROW1    = 3'd4,
        REG_ROT_ROW2    = 3'd5,
        REG_TRANSLATION = 3'd6,
        REG_FRAME_SIZE  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [SCALE_W-1:0]         depth_scale;
        logic [63:0]                depth_intr;
        logic [63:0]                color_intr;
        logic [2:0][ROW_W-1:0]      rot_row;
        logic [ROW_W-1:0]           translation;
        logic [FRAME_W-1:0]         frame_size;
    } t_cfg;

endpackage

// ----- sv/d2c_regs.sv -----
`timescale 1ns / 1ps

module d2c_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [d2c_pkg::PADDR_W-1:0]  paddr,
    input  logic [d2c_pkg::PDATA_W-1:0]  pwdata,
    output logic [d2c_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output d2c_pkg::t_cfg                o_cfg
);

    d2c_pkg::t_cfg     r_cfg;
    d2c_pkg::t_cfg     n_cfg;
    d2c_pkg::t_reg_idx w_idx;

    assign w_idx  = d2c_pkg::t_reg_idx'(paddr[d2c_pkg::PADDR_W-1:3]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (psel && penable && pwrite) begin
            unique case (w_idx)
                d2c_pkg::REG_DEPTH_SCALE: n_cfg.depth_scale = pwdata[d2c_pkg::SCALE_W-1:0];
                d2c_pkg::REG_DEPTH_INTR:  n_cfg.depth_intr  = pwdata;
                d2c_pkg::REG_COLOR_INTR:  n_cfg.color_intr  = pwdata;
                d2c_pkg::REG_ROT_ROW0:    n_cfg.rot_row[0]  = pwdata[d2c_pkg::ROW_W-1:0];
                d2c_pkg::REG_ROT_ROW1:    n_cfg.rot_row[1]  = pwdata[d2c_pkg::ROW_W-1:0];
                d2c_pkg::REG_ROT_ROW2:    n_cfg.rot_row[2]  = pwdata[d2c_pkg::ROW_W-1:0];
                d2c_pkg::REG_TRANSLATION: n_cfg.translation = pwdata[d2c_pkg::ROW_W-1:0];
                d2c_pkg::REG_FRAME_SIZE:  n_cfg.frame_size  = pwdata[d2c_pkg::FRAME_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (w_idx)
            d2c_pkg::REG_DEPTH_SCALE: prdata = d2c_pkg::PDATA_W'(r_cfg.depth_scale);
            d2c_pkg::REG_DEPTH_INTR:  prdata = r_cfg.depth_intr;
            d2c_pkg::REG_COLOR_INTR:  prdata = r_cfg.color_intr;
            d2c_pkg::REG_ROT_ROW0:    prdata = d2c_pkg::PDATA_W'(r_cfg.rot_row[0]);
            d2c_pkg::REG_ROT_ROW1:    prdata = d2c_pkg::PDATA_W'(r_cfg.rot_row[1]);
            d2c_pkg::REG_ROT_ROW2:    prdata = d2c_pkg::PDATA_W'(r_cfg.rot_row[2]);
            d2c_pkg::REG_TRANSLATION: prdata = d2c_pkg::PDATA_W'(r_cfg.translation);
            d2c_pkg::REG_FRAME_SIZE:  prdata = d2c_pkg::PDATA_W'(r_cfg.frame_size);
        endcase
    end

endmodule

// ----- sv/d2c_norm_div.sv -----
`timescale 1ns / 1ps

module d2c_norm_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [d2c_pkg::DIFF_W-1:0]   i_diff,
    input  logic [d2c_pkg::FOC_W-1:0]    i_f,
    output logic [d2c_pkg::NMAG_W-1:0]   o_mag,
    output logic                         o_neg
);

    logic [d2c_pkg::DIFF_W-1:0] w_abs;
    logic [d2c_pkg::FOC_W-1:0]  w_rem [d2c_pkg::ND_STAGES+1];
    logic [d2c_pkg::NDV_W-1:0]  w_dvd [d2c_pkg::ND_STAGES+1];
    logic [d2c_pkg::NDV_W-1:0]  w_quo [d2c_pkg::ND_STAGES+1];
    logic                       w_neg [d2c_pkg::ND_STAGES+1];

    logic [d2c_pkg::FOC_W-1:0]  r_rem [d2c_pkg::ND_STAGES];
    logic [d2c_pkg::NDV_W-1:0]  r_dvd [d2c_pkg::ND_STAGES];
    logic [d2c_pkg::NDV_W-1:0]  r_quo [d2c_pkg::ND_STAGES];
    logic                       r_neg [d2c_pkg::ND_STAGES];
    logic [d2c_pkg::FOC_W-1:0]  n_rem [d2c_pkg::ND_STAGES];
    logic [d2c_pkg::NDV_W-1:0]  n_dvd [d2c_pkg::ND_STAGES];
    logic [d2c_pkg::NDV_W-1:0]  n_quo [d2c_pkg::ND_STAGES];

    assign w_abs    = i_diff[d2c_pkg::DIFF_W-1] ? ('0 - i_diff) : i_diff;
    assign w_neg[0] = i_diff[d2c_pkg::DIFF_W-1];
    assign w_rem[0] = '0;
    assign w_quo[0] = '0;
    assign w_dvd[0] = d2c_pkg::NDV_W'({w_abs[d2c_pkg::DIFF_W-2:0],
                                       {d2c_pkg::Q_FRAC{1'b0}}});

    for (genvar s = 0; s < d2c_pkg::ND_STAGES; s++) begin : g_stage
        always_comb begin : p_step
            logic [d2c_pkg::FOC_W:0]   v_t;
            logic [d2c_pkg::FOC_W-1:0] v_rem;
            logic [d2c_pkg::NDV_W-1:0] v_dvd;
            logic [d2c_pkg::NDV_W-1:0] v_quo;
            v_rem = w_rem[s];
            v_dvd = w_dvd[s];
            v_quo = w_quo[s];
            for (int k = 0; k < d2c_pkg::ND_STEP; k++) begin
                v_t   = {v_rem, v_dvd[d2c_pkg::NDV_W-1]};
                v_dvd = {v_dvd[d2c_pkg::NDV_W-2:0], 1'b0};
                if (v_t >= {1'b0, i_f}) begin
                    v_t   = v_t - {1'b0, i_f};
                    v_quo = {v_quo[d2c_pkg::NDV_W-2:0], 1'b1};
                end else begin
                    v_quo = {v_quo[d2c_pkg::NDV_W-2:0], 1'b0};
                end
                v_rem = v_t[d2c_pkg::FOC_W-1:0];
            end
            n_rem[s] = v_rem;
            n_dvd[s] = v_dvd;
            n_quo[s] = v_quo;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem[s];
                r_dvd[s] <= n_dvd[s];
                r_quo[s] <= n_quo[s];
                r_neg[s] <= w_neg[s];
            end
        end

        assign w_rem[s+1] = r_rem[s];
        assign w_dvd[s+1] = r_dvd[s];
        assign w_quo[s+1] = r_quo[s];
        assign w_neg[s+1] = r_neg[s];
    end

    // saturate to 2^31-1
    assign o_mag = (|w_quo[d2c_pkg::ND_STAGES][d2c_pkg::NDV_W-1:d2c_pkg::NMAG_W])
                 ? '1 : w_quo[d2c_pkg::ND_STAGES][d2c_pkg::NMAG_W-1:0];
    assign o_neg = w_neg[d2c_pkg::ND_STAGES];

endmodule

// ----- sv/d2c_rnd_div.sv -----
`timescale 1ns / 1ps

module d2c_rnd_div (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [d2c_pkg::PNUM_W-1:0]     i_num,
    input  logic [d2c_pkg::PDEN_W-1:0]     i_den,
    output logic [d2c_pkg::COORD_BITS-1:0] o_quo,
    output logic                           o_ok
);

    logic [d2c_pkg::PNUM_W-1:0]     r_rem [d2c_pkg::PRJ_STAGES];
    logic [d2c_pkg::PDEN_W-1:0]     r_den [d2c_pkg::PRJ_STAGES];
    logic [d2c_pkg::COORD_BITS-1:0] r_quo [d2c_pkg::PRJ_STAGES];
    logic                           r_ok  [d2c_pkg::PRJ_STAGES];
    logic [d2c_pkg::PNUM_W-1:0]     n_rem [d2c_pkg::PRJ_STAGES];
    logic [d2c_pkg::COORD_BITS-1:0] n_quo [d2c_pkg::PRJ_STAGES];
    logic                           n_ok;

    // quotient must fit in COORD_BITS
    assign n_ok     = d2c_pkg::CMP_W'(i_num)
                    < (d2c_pkg::CMP_W'(i_den) << d2c_pkg::COORD_BITS);
    assign n_rem[0] = i_num;
    assign n_quo[0] = '0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_rem[0];
            r_den[0] <= i_den;
            r_quo[0] <= n_quo[0];
            r_ok[0]  <= n_ok;
        end
    end

    for (genvar s = 1; s < d2c_pkg::PRJ_STAGES; s++) begin : g_stage
        always_comb begin : p_step
            logic [d2c_pkg::CMP_W-1:0] v_sh;
            logic [d2c_pkg::CMP_W-1:0] v_r;
            v_sh = d2c_pkg::CMP_W'(r_den[s-1]) << (d2c_pkg::COORD_BITS - s);
            v_r  = d2c_pkg::CMP_W'(r_rem[s-1]);
            if (v_r >= v_sh) begin
                n_rem[s] = d2c_pkg::PNUM_W'(v_r - v_sh);
                n_quo[s] = {r_quo[s-1][d2c_pkg::COORD_BITS-2:0], 1'b1};
            end else begin
                n_rem[s] = r_rem[s-1];
                n_quo[s] = {r_quo[s-1][d2c_pkg::COORD_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem[s];
                r_den[s] <= r_den[s-1];
                r_quo[s] <= n_quo[s];
                r_ok[s]  <= r_ok[s-1];
            end
        end
    end

    assign o_quo = r_quo[d2c_pkg::PRJ_STAGES-1];
    assign o_ok  = r_ok[d2c_pkg::PRJ_STAGES-1];

endmodule

// ----- sv/depth_to_color_registration.sv -----
`timescale 1ns / 1ps
// Depth-to-color registration, one depth pixel per transaction.
// Input channel (i_in_valid / o_in_ready): column, row and raw depth of a
// depth pixel. Output channel (o_out_valid / i_out_ready): target column,
// target row and metric depth (Q16.16) of one write into the color frame.
// A pixel yields zero or one output transaction; pixels with no sample, a
// zero depth focal length, a point behind the color camera or a target
// outside the frame give none and leave a bubble.
// Registers are written over the APB port by the user, who must do so only
// while the block is idle; the block itself does not enforce this.
// The normalizing divider has 8 stages and the rounding projection divider
// has COORD_BITS+1 stages.
// Throughput: one pixel per cycle while the pipeline is not stalled.
// Reset: the configuration registers clear to zero and the pipeline empties.
// Stall: while an output waits and i_out_ready is low, the whole pipeline
// holds and o_in_ready is low; nothing is lost or repeated.
module depth_to_color_registration (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [d2c_pkg::PADDR_W-1:0]    paddr,
    input  logic [d2c_pkg::PDATA_W-1:0]    pwdata,
    output logic [d2c_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [d2c_pkg::COORD_BITS-1:0] i_pixel_col,
    input  logic [d2c_pkg::COORD_BITS-1:0] i_pixel_row,
    input  logic [d2c_pkg::RAW_W-1:0]      i_raw_depth,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [d2c_pkg::COORD_BITS-1:0] o_target_col,
    output logic [d2c_pkg::COORD_BITS-1:0] o_target_row,
    output logic [d2c_pkg::DQ_W-1:0]       o_metric_depth
);

    d2c_pkg::t_cfg w_cfg;
    logic          w_en;
    logic          w_in_acc;

    d2c_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    logic [d2c_pkg::FOC_W-1:0] w_dfx, w_dfy, w_dcx, w_dcy;
    logic [d2c_pkg::FOC_W-1:0] w_cfx, w_cfy, w_ccx, w_ccy;
    logic [d2c_pkg::COORD_BITS-1:0] w_width, w_height;
    logic signed [d2c_pkg::ROT_W-1:0] w_rot [3][3];
    logic signed [d2c_pkg::ROT_W-1:0] w_t   [3];

    assign w_dfx = w_cfg.depth_intr[15:0];
    assign w_dfy = w_cfg.depth_intr[31:16];
    assign w_dcx = w_cfg.depth_intr[47:32];
    assign w_dcy = w_cfg.depth_intr[63:48];
    assign w_cfx = w_cfg.color_intr[15:0];
    assign w_cfy = w_cfg.color_intr[31:16];
    assign w_ccx = w_cfg.color_intr[47:32];
    assign w_ccy = w_cfg.color_intr[63:48];
    assign w_width  = w_cfg.frame_size[d2c_pkg::COORD_BITS-1:0];
    assign w_height = w_cfg.frame_size[d2c_pkg::FRAME_W-1:d2c_pkg::COORD_BITS];

    for (genvar i = 0; i < 3; i++) begin : g_cfg
        for (genvar j = 0; j < 3; j++) begin : g_ent
            assign w_rot[i][j] = w_cfg.rot_row[i][d2c_pkg::ROT_W*j +: d2c_pkg::ROT_W];
        end
        assign w_t[i] = w_cfg.translation[d2c_pkg::ROT_W*i +: d2c_pkg::ROT_W];
    end

    logic r_out_valid;

    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;
    assign w_in_acc   = i_in_valid && w_en;

    // stage 1: depth product, pixel offsets
    logic                         r1_valid;
    logic [d2c_pkg::P_W-1:0]      r1_p;
    logic [d2c_pkg::DIFF_W-1:0]   r1_dx, r1_dy;
    logic                         n1_valid;

    assign n1_valid = w_in_acc && (i_raw_depth != '0) && (w_cfg.depth_scale != '0)
                   && (w_dfx != '0) && (w_dfy != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= n1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_p  <= d2c_pkg::P_W'(i_raw_depth) * d2c_pkg::P_W'(w_cfg.depth_scale);
            r1_dx <= d2c_pkg::DIFF_W'({i_pixel_col, {d2c_pkg::INTR_FRAC{1'b0}}})
                   - d2c_pkg::DIFF_W'(w_dcx);
            r1_dy <= d2c_pkg::DIFF_W'({i_pixel_row, {d2c_pkg::INTR_FRAC{1'b0}}})
                   - d2c_pkg::DIFF_W'(w_dcy);
        end
    end

    // normalized coordinates
    logic [d2c_pkg::NMAG_W-1:0] w_xmag, w_ymag;
    logic                       w_xneg, w_yneg;

    d2c_norm_div u_ndiv_x (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_diff (r1_dx),
        .i_f    (w_dfx),
        .o_mag  (w_xmag),
        .o_neg  (w_xneg)
    );

    d2c_norm_div u_ndiv_y (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_diff (r1_dy),
        .i_f    (w_dfy),
        .o_mag  (w_ymag),
        .o_neg  (w_yneg)
    );

    logic                      r_nd_v  [d2c_pkg::ND_STAGES];
    logic [d2c_pkg::DQ_W-1:0]  r_nd_dq [d2c_pkg::ND_STAGES];

    for (genvar s = 0; s < d2c_pkg::ND_STAGES; s++) begin : g_nd
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_nd_v[s] <= 1'b0;
            end else if (w_en) begin
                r_nd_v[s] <= (s == 0) ? r1_valid : r_nd_v[(s == 0) ? 0 : s-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_nd_dq[s] <= (s == 0) ? r1_p[d2c_pkg::P_W-1:d2c_pkg::Q_FRAC]
                                       : r_nd_dq[(s == 0) ? 0 : s-1];
            end
        end
    end

    // stage 2: lateral products
    logic                       r2_valid;
    logic [d2c_pkg::MX_W-1:0]   r2_mx, r2_my;
    logic                       r2_nx, r2_ny;
    logic [d2c_pkg::DQ_W-1:0]   r2_dq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= r_nd_v[d2c_pkg::ND_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_mx <= d2c_pkg::MX_W'(r_nd_dq[d2c_pkg::ND_STAGES-1]) * d2c_pkg::MX_W'(w_xmag);
            r2_my <= d2c_pkg::MX_W'(r_nd_dq[d2c_pkg::ND_STAGES-1]) * d2c_pkg::MX_W'(w_ymag);
            r2_nx <= w_xneg;
            r2_ny <= w_yneg;
            r2_dq <= r_nd_dq[d2c_pkg::ND_STAGES-1];
        end
    end

    // stage 3: shift, saturate, sign
    logic                               r3_valid;
    logic signed [d2c_pkg::LAT_W-1:0]   r3_vec [3];
    logic [d2c_pkg::DQ_W-1:0]           r3_dq;
    logic signed [d2c_pkg::LAT_W-1:0]   n3_x, n3_y;

    always_comb begin : p_lat
        logic [d2c_pkg::MX_W-d2c_pkg::Q_FRAC-1:0] v_sx, v_sy;
        logic [d2c_pkg::LAT_W-1:0]                v_ax, v_ay;
        v_sx = r2_mx[d2c_pkg::MX_W-1:d2c_pkg::Q_FRAC];
        v_sy = r2_my[d2c_pkg::MX_W-1:d2c_pkg::Q_FRAC];
        v_ax = (|v_sx[d2c_pkg::MX_W-d2c_pkg::Q_FRAC-1:d2c_pkg::LAT_W-1])
             ? {1'b0, {(d2c_pkg::LAT_W-1){1'b1}}} : {1'b0, v_sx[d2c_pkg::LAT_W-2:0]};
        v_ay = (|v_sy[d2c_pkg::MX_W-d2c_pkg::Q_FRAC-1:d2c_pkg::LAT_W-1])
             ? {1'b0, {(d2c_pkg::LAT_W-1){1'b1}}} : {1'b0, v_sy[d2c_pkg::LAT_W-2:0]};
        n3_x = r2_nx ? ('0 - v_ax) : v_ax;
        n3_y = r2_ny ? ('0 - v_ay) : v_ay;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_vec[0] <= n3_x;
            r3_vec[1] <= n3_y;
            r3_vec[2] <= d2c_pkg::LAT_W'(r2_dq);
            r3_dq     <= r2_dq;
        end
    end

    // stage 4: rotation products
    logic                                r4_valid;
    logic signed [d2c_pkg::PROD_W-1:0]   r4_prod [3][3];
    logic [d2c_pkg::DQ_W-1:0]            r4_dq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (w_en) begin
            r4_valid <= r3_valid;
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_rmul
        for (genvar j = 0; j < 3; j++) begin : g_col
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r4_prod[i][j] <= w_rot[i][j] * r3_vec[j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_dq <= r3_dq;
        end
    end

    // stage 5: row sums
    logic                               r5_valid;
    logic signed [d2c_pkg::ACC_W-1:0]   r5_acc [3];
    logic [d2c_pkg::DQ_W-1:0]           r5_dq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (w_en) begin
            r5_valid <= r4_valid;
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_rsum
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r5_acc[i] <= d2c_pkg::ACC_W'(r4_prod[i][0]) + d2c_pkg::ACC_W'(r4_prod[i][1])
                           + d2c_pkg::ACC_W'(r4_prod[i][2]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_dq <= r4_dq;
        end
    end

    // stage 6: floor shift, translation, depth guard
    logic                              r6_valid;
    logic signed [d2c_pkg::PT_W-1:0]   r6_p [3];
    logic [d2c_pkg::DQ_W-1:0]          r6_dq;
    logic signed [d2c_pkg::PT_W-1:0]   n6_p [3];
    logic                              w_pz_pos;

    for (genvar i = 0; i < 3; i++) begin : g_tr
        assign n6_p[i] = d2c_pkg::PT_W'(r5_acc[i] >>> d2c_pkg::ROT_FRAC)
                       + d2c_pkg::PT_W'(w_t[i]);
    end

    assign w_pz_pos = !n6_p[2][d2c_pkg::PT_W-1] && (n6_p[2] != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (w_en) begin
            r6_valid <= r5_valid && w_pz_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_p[0] <= n6_p[0];
            r6_p[1] <= n6_p[1];
            r6_p[2] <= n6_p[2];
            r6_dq   <= r5_dq;
        end
    end

    // stage 7: projection products
    logic                               r7_valid;
    logic signed [d2c_pkg::PRJ_W-1:0]   r7_fx, r7_cx, r7_fy, r7_cy;
    logic signed [d2c_pkg::PT_W-1:0]    r7_pz;
    logic [d2c_pkg::DQ_W-1:0]           r7_dq;
    logic signed [d2c_pkg::FOC_W:0]     w_cfx_s, w_cfy_s, w_ccx_s, w_ccy_s;

    assign w_cfx_s = {1'b0, w_cfx};
    assign w_cfy_s = {1'b0, w_cfy};
    assign w_ccx_s = {1'b0, w_ccx};
    assign w_ccy_s = {1'b0, w_ccy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
        end else if (w_en) begin
            r7_valid <= r6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_fx <= w_cfx_s * r6_p[0];
            r7_cx <= w_ccx_s * r6_p[2];
            r7_fy <= w_cfy_s * r6_p[1];
            r7_cy <= w_ccy_s * r6_p[2];
            r7_pz <= r6_p[2];
            r7_dq <= r6_dq;
        end
    end

    // stage 8: numerators
    logic                               r8_valid;
    logic signed [d2c_pkg::SUM_W-1:0]   r8_nc, r8_nr;
    logic signed [d2c_pkg::PT_W-1:0]    r8_pz;
    logic [d2c_pkg::DQ_W-1:0]           r8_dq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_valid <= 1'b0;
        end else if (w_en) begin
            r8_valid <= r7_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_nc <= d2c_pkg::SUM_W'(r7_fx) + d2c_pkg::SUM_W'(r7_cx);
            r8_nr <= d2c_pkg::SUM_W'(r7_fy) + d2c_pkg::SUM_W'(r7_cy);
            r8_pz <= r7_pz;
            r8_dq <= r7_dq;
        end
    end

    // stage 9: rounding operands, (2|n| + d) / 2d with d = 16 pz
    logic                              r9_valid;
    logic [d2c_pkg::PNUM_W-1:0]        r9_numc, r9_numr;
    logic [d2c_pkg::PDEN_W-1:0]        r9_den;
    logic                              r9_negc, r9_negr;
    logic [d2c_pkg::DQ_W-1:0]          r9_dq;
    logic [d2c_pkg::SUM_W-1:0]         w_mc, w_mr;
    logic [d2c_pkg::PNUM_W-1:0]        w_d;

    assign w_mc = r8_nc[d2c_pkg::SUM_W-1] ? ('0 - r8_nc) : r8_nc;
    assign w_mr = r8_nr[d2c_pkg::SUM_W-1] ? ('0 - r8_nr) : r8_nr;
    assign w_d  = d2c_pkg::PNUM_W'({r8_pz, 4'b0000});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_valid <= 1'b0;
        end else if (w_en) begin
            r9_valid <= r8_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_numc <= d2c_pkg::PNUM_W'({w_mc, 1'b0}) + w_d;
            r9_numr <= d2c_pkg::PNUM_W'({w_mr, 1'b0}) + w_d;
            r9_den  <= d2c_pkg::PDEN_W'({r8_pz, 5'b00000});
            r9_negc <= r8_nc[d2c_pkg::SUM_W-1];
            r9_negr <= r8_nr[d2c_pkg::SUM_W-1];
            r9_dq   <= r8_dq;
        end
    end

    logic [d2c_pkg::COORD_BITS-1:0] w_qc, w_qr;
    logic                           w_okc, w_okr;

    d2c_rnd_div u_rdiv_c (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r9_numc),
        .i_den (r9_den),
        .o_quo (w_qc),
        .o_ok  (w_okc)
    );

    d2c_rnd_div u_rdiv_r (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r9_numr),
        .i_den (r9_den),
        .o_quo (w_qr),
        .o_ok  (w_okr)
    );

    logic                      r_pj_v    [d2c_pkg::PRJ_STAGES];
    logic                      r_pj_negc [d2c_pkg::PRJ_STAGES];
    logic                      r_pj_negr [d2c_pkg::PRJ_STAGES];
    logic [d2c_pkg::DQ_W-1:0]  r_pj_dq   [d2c_pkg::PRJ_STAGES];

    for (genvar s = 0; s < d2c_pkg::PRJ_STAGES; s++) begin : g_pj
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pj_v[s] <= 1'b0;
            end else if (w_en) begin
                r_pj_v[s] <= (s == 0) ? r9_valid : r_pj_v[(s == 0) ? 0 : s-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_pj_negc[s] <= (s == 0) ? r9_negc : r_pj_negc[(s == 0) ? 0 : s-1];
                r_pj_negr[s] <= (s == 0) ? r9_negr : r_pj_negr[(s == 0) ? 0 : s-1];
                r_pj_dq[s]   <= (s == 0) ? r9_dq   : r_pj_dq[(s == 0) ? 0 : s-1];
            end
        end
    end

    // output register
    logic                            n_out_valid;
    logic [d2c_pkg::COORD_BITS-1:0]  r_out_col, r_out_row;
    logic [d2c_pkg::DQ_W-1:0]        r_out_depth;
    logic                            w_pj_v;

    assign w_pj_v = r_pj_v[d2c_pkg::PRJ_STAGES-1];

    // a negative numerator survives only when it rounds to zero
    assign n_out_valid = w_pj_v && w_okc && w_okr
        && (!r_pj_negc[d2c_pkg::PRJ_STAGES-1] || (w_qc == '0))
        && (!r_pj_negr[d2c_pkg::PRJ_STAGES-1] || (w_qr == '0))
        && (w_qc < w_width) && (w_qr < w_height);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_col   <= w_qc;
            r_out_row   <= w_qr;
            r_out_depth <= r_pj_dq[d2c_pkg::PRJ_STAGES-1];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_target_col   = r_out_col;
    assign o_target_row   = r_out_row;
    assign o_metric_depth = r_out_depth;

`ifndef SYNTHESIS
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |=> $stable(r1_valid) && $stable(r9_valid) && $stable(w_pj_v))
        else $error("pipeline moved during stall");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_pj_v) && $past(w_okc) && $past(w_okr))
        else $error("output without live projected item");
`endif

endmodule
